[hdl/sbm_pkg.sv]
// Shared types, constants and the sprite height table for the sprite band multiplexer.
`default_nettype none
package sbm_pkg;

   localparam int SLOT_CAPACITY_DEF = 64;
   localparam int LIST_DEPTH_DEF    = 128;
   localparam int SCREEN_LINES_DEF  = 192;

   localparam int OP_W       = 2;
   localparam int ATTR_W     = 16;
   localparam int LINE_W     = 8;
   localparam int BOTTOM_W   = 9;
   localparam int HEIGHT_W   = 7;
   localparam int BAND_W     = 5;
   localparam int BAND_MAX   = 16;
   localparam int SLOT_W     = 7;
   localparam int SLOT_IDX_W = 6;
   localparam int ENTRY_W    = BOTTOM_W + 3 * ATTR_W;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_EVAL   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic {
      CSR_ENABLE      = 1'b0,
      CSR_BAND_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_HIDE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic clear;
      logic append;
      logic start;
      logic advance;
      logic push_sprite;
      logic finish_walk;
      logic push_hide;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic walk_done;
      logic hit;
      logic can_push;
      logic hide_done;
      logic pend_valid;
   } status_type;

   // Rows are shape (square, tall, wide, forbidden), columns are size.
   function automatic logic [HEIGHT_W-1:0] height_lookup(input logic [1:0] shape,
                                                         input logic [1:0] size);
      logic [HEIGHT_W-1:0] h;
      case ({shape, size})
         4'b0000: h = 7'd8;
         4'b0001: h = 7'd16;
         4'b0010: h = 7'd32;
         4'b0011: h = 7'd64;
         4'b0100: h = 7'd16;
         4'b0101: h = 7'd32;
         4'b0110: h = 7'd32;
         4'b0111: h = 7'd64;
         4'b1000: h = 7'd8;
         4'b1001: h = 7'd8;
         4'b1010: h = 7'd16;
         4'b1011: h = 7'd32;
         default: h = 7'd8;
      endcase
      return h;
   endfunction

endpackage
`default_nettype wire

[hdl/sbm_ctrl.sv]
// Controller state machine that sequences request handling, the list walk and the hide pass.
`default_nettype none
module sbm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [1:0]         req_operation,
   output logic                    req_stall,
   input  wire sbm_pkg::status_type status,
   output sbm_pkg::cmd_type        cmd,
   output sbm_pkg::state_type      state
);
   import sbm_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;
   op_type    op;

   assign op     = op_type'(req_operation);
   assign accept = req_valid && (state_ff == ST_IDLE);
   assign state  = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (op == OP_EVAL) && status.enable) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_HIDE;
            end
         end
         ST_HIDE: begin
            if (status.hide_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid || status.can_push) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.clear  = accept && (op == OP_CLEAR);
            cmd.append = accept && (op == OP_APPEND);
            cmd.start  = accept && (op == OP_EVAL) && status.enable;
         end
         ST_WALK: begin
            if (status.walk_done) begin
               cmd.finish_walk = 1'b1;
            end else if (status.hit) begin
               cmd.push_sprite = status.can_push;
               cmd.advance     = status.can_push;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_HIDE: begin
            cmd.push_hide = !status.hide_done && status.can_push;
         end
         ST_FLUSH: begin
            cmd.flush = status.pend_valid && status.can_push;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

[hdl/sbm_datapath.sv]
// Datapath with the sprite list memory, walk counters, band compare and result registers.
`default_nettype none
module sbm_datapath #(
   parameter int SLOT_CAPACITY = sbm_pkg::SLOT_CAPACITY_DEF,
   parameter int LIST_DEPTH    = sbm_pkg::LIST_DEPTH_DEF,
   parameter int SCREEN_LINES  = sbm_pkg::SCREEN_LINES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sbm_pkg::cmd_type              cmd,
   output sbm_pkg::status_type                status,
   input  wire logic [sbm_pkg::ATTR_W-1:0]    req_attr_zero,
   input  wire logic [sbm_pkg::ATTR_W-1:0]    req_attr_one,
   input  wire logic [sbm_pkg::ATTR_W-1:0]    req_attr_two,
   input  wire logic [sbm_pkg::LINE_W-1:0]    req_band_start,
   input  wire logic                          csr_write,
   input  wire logic                          csr_index,
   input  wire logic [sbm_pkg::BAND_W-1:0]    csr_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [sbm_pkg::SLOT_IDX_W-1:0]     rsp_slot,
   output logic [sbm_pkg::ATTR_W-1:0]         rsp_out_attr_zero,
   output logic [sbm_pkg::ATTR_W-1:0]         rsp_out_attr_one,
   output logic [sbm_pkg::ATTR_W-1:0]         rsp_out_attr_two,
   output logic                               rsp_hide,
   output logic                               rsp_last
);
   import sbm_pkg::*;

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   logic [ENTRY_W-1:0]  mem [LIST_DEPTH];
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                rd_en;
   logic [ENTRY_W-1:0]  wr_data;
   logic                wr_en;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [SLOT_W-1:0]   used_ff, used_in;
   logic [SLOT_W-1:0]   prev_ff, prev_in;
   logic [SLOT_W-1:0]   hide_idx_ff, hide_idx_in;
   logic [SLOT_W-1:0]   hide_limit_ff, hide_limit_in;
   logic                enable_ff, enable_in;
   logic [BAND_W-1:0]   band_height_ff, band_height_in;
   logic [LINE_W-1:0]   start_ff;
   logic [BOTTOM_W-1:0] end_ff;

   logic [BAND_W-1:0]   band_clamped;
   logic [BOTTOM_W-1:0] end_raw;
   logic [BOTTOM_W-1:0] end_calc;
   logic [BOTTOM_W-1:0] rd_bottom;
   logic [LINE_W-1:0]   rd_y;

   logic                pend_valid_ff, pend_valid_in;
   logic [SLOT_IDX_W-1:0] pend_slot_ff;
   logic [3*ATTR_W-1:0] pend_attr_ff;
   logic                pend_hide_ff;
   logic                push;
   logic                out_free;
   logic                out_load;
   logic                out_valid_ff, out_valid_in;
   logic [SLOT_IDX_W-1:0] out_slot_ff;
   logic [3*ATTR_W-1:0] out_attr_ff;
   logic                out_hide_ff;
   logic                out_last_ff;

   // The list memory holds {bottom, word 2, word 1, word 0}.
   assign wr_en   = cmd.append && (count_ff < CNT_W'(LIST_DEPTH));
   assign wr_data = {BOTTOM_W'({1'b0, req_attr_zero[LINE_W-1:0]})
                        + BOTTOM_W'(height_lookup(req_attr_zero[15:14], req_attr_one[15:14])),
                     req_attr_two, req_attr_one, req_attr_zero};
   assign rd_en   = cmd.start || cmd.advance;
   assign rd_addr = cmd.start ? '0 : IDX_W'(idx_ff + CNT_W'(1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_bottom = rd_data_ff[ENTRY_W-1 -: BOTTOM_W];
   assign rd_y      = rd_data_ff[LINE_W-1:0];

   always_comb begin
      if (band_height_ff == '0) begin
         band_clamped = BAND_W'(1);
      end else if (band_height_ff > BAND_W'(BAND_MAX)) begin
         band_clamped = BAND_W'(BAND_MAX);
      end else begin
         band_clamped = band_height_ff;
      end
      end_raw = BOTTOM_W'(req_band_start) + BOTTOM_W'(band_clamped) - BOTTOM_W'(1);
      if (end_raw > BOTTOM_W'(SCREEN_LINES)) begin
         end_calc = BOTTOM_W'(SCREEN_LINES);
      end else begin
         end_calc = end_raw;
      end
   end

   always_comb begin
      count_in       = count_ff;
      idx_in         = idx_ff;
      used_in        = used_ff;
      prev_in        = prev_ff;
      hide_idx_in    = hide_idx_ff;
      hide_limit_in  = hide_limit_ff;
      enable_in      = enable_ff;
      band_height_in = band_height_ff;
      if (cmd.clear) begin
         count_in = '0;
      end
      if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.start) begin
         idx_in  = '0;
         used_in = '0;
      end
      if (cmd.advance) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.push_sprite) begin
         used_in = used_ff + SLOT_W'(1);
      end
      if (cmd.finish_walk) begin
         prev_in       = used_ff;
         hide_idx_in   = used_ff;
         hide_limit_in = prev_ff;
      end
      if (cmd.push_hide) begin
         hide_idx_in = hide_idx_ff + SLOT_W'(1);
      end
      if (csr_write) begin
         if (csr_index == CSR_ENABLE) begin
            enable_in = csr_data[0];
            if (csr_data[0] && !enable_ff) begin
               prev_in = SLOT_W'(SLOT_CAPACITY);
            end
         end else begin
            band_height_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         idx_ff         <= '0;
         used_ff        <= '0;
         prev_ff        <= SLOT_W'(SLOT_CAPACITY);
         hide_idx_ff    <= '0;
         hide_limit_ff  <= '0;
         enable_ff      <= 1'b0;
         band_height_ff <= BAND_W'(4);
      end else begin
         count_ff       <= count_in;
         idx_ff         <= idx_in;
         used_ff        <= used_in;
         prev_ff        <= prev_in;
         hide_idx_ff    <= hide_idx_in;
         hide_limit_ff  <= hide_limit_in;
         enable_ff      <= enable_in;
         band_height_ff <= band_height_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         start_ff <= req_band_start;
         end_ff   <= end_calc;
      end
   end

   // One result waits in the pending stage so that the final one can carry last.
   assign out_free = !out_valid_ff || !rsp_stall;
   assign push     = cmd.push_sprite || cmd.push_hide;
   assign out_load = (push && pend_valid_ff) || cmd.flush;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (push) begin
         pend_valid_in = 1'b1;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_sprite) begin
         pend_slot_ff <= used_ff[SLOT_IDX_W-1:0];
         pend_attr_ff <= rd_data_ff[3*ATTR_W-1:0];
         pend_hide_ff <= 1'b0;
      end else if (cmd.push_hide) begin
         pend_slot_ff <= hide_idx_ff[SLOT_IDX_W-1:0];
         pend_attr_ff <= '0;
         pend_hide_ff <= 1'b1;
      end
      if (out_load) begin
         out_slot_ff <= pend_slot_ff;
         out_attr_ff <= pend_attr_ff;
         out_hide_ff <= pend_hide_ff;
         out_last_ff <= cmd.flush;
      end
   end

   assign status.enable     = enable_ff;
   assign status.walk_done  = (idx_ff >= count_ff) || (used_ff >= SLOT_W'(SLOT_CAPACITY));
   assign status.hit        = (rd_bottom >= BOTTOM_W'(start_ff))
                              && (BOTTOM_W'(rd_y) <= end_ff);
   assign status.can_push   = !pend_valid_ff || out_free;
   assign status.hide_done  = (hide_idx_ff >= hide_limit_ff)
                              || (hide_idx_ff >= SLOT_W'(SLOT_CAPACITY));
   assign status.pend_valid = pend_valid_ff;

   assign rsp_valid         = out_valid_ff;
   assign rsp_slot          = out_slot_ff;
   assign rsp_out_attr_zero = out_attr_ff[ATTR_W-1:0];
   assign rsp_out_attr_one  = out_attr_ff[2*ATTR_W-1:ATTR_W];
   assign rsp_out_attr_two  = out_attr_ff[3*ATTR_W-1:2*ATTR_W];
   assign rsp_hide          = out_hide_ff;
   assign rsp_last          = out_last_ff;

endmodule
`default_nettype wire

[hdl/sprite_band_multiplexer_core.sv]
// Operation: clear and append act at once; an evaluation walks the list entries through the
// registered list memory read, then emits hide results, and output stall stretches it.
// Throughput: one clear or append per cycle while no evaluation is in progress; one evaluation at a time.
// Reset: control, counters and valid flags clear, the band height is set to 4 and the slot history is
// set to full capacity; the sprite list memory is not cleared, since only entries below the count are read.
`default_nettype none
module sprite_band_multiplexer_core #(
   parameter int SLOT_CAPACITY = sbm_pkg::SLOT_CAPACITY_DEF,
   parameter int LIST_DEPTH    = sbm_pkg::LIST_DEPTH_DEF,
   parameter int SCREEN_LINES  = sbm_pkg::SCREEN_LINES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [sbm_pkg::OP_W-1:0]      req_operation,
   input  wire logic [sbm_pkg::ATTR_W-1:0]    req_attr_zero,
   input  wire logic [sbm_pkg::ATTR_W-1:0]    req_attr_one,
   input  wire logic [sbm_pkg::ATTR_W-1:0]    req_attr_two,
   input  wire logic [sbm_pkg::LINE_W-1:0]    req_band_start,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [sbm_pkg::SLOT_IDX_W-1:0]     rsp_slot,
   output logic [sbm_pkg::ATTR_W-1:0]         rsp_out_attr_zero,
   output logic [sbm_pkg::ATTR_W-1:0]         rsp_out_attr_one,
   output logic [sbm_pkg::ATTR_W-1:0]         rsp_out_attr_two,
   output logic                               rsp_hide,
   output logic                               rsp_last,
   input  wire logic                          csr_write,
   input  wire logic                          csr_index,
   input  wire logic [sbm_pkg::BAND_W-1:0]    csr_data
);
   import sbm_pkg::*;

   cmd_type    cmd;
   status_type status;
   state_type  state;

   sbm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd),
      .state         (state)
   );

   sbm_datapath #(
      .SLOT_CAPACITY (SLOT_CAPACITY),
      .LIST_DEPTH    (LIST_DEPTH),
      .SCREEN_LINES  (SCREEN_LINES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_attr_zero     (req_attr_zero),
      .req_attr_one      (req_attr_one),
      .req_attr_two      (req_attr_two),
      .req_band_start    (req_band_start),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slot          (rsp_slot),
      .rsp_out_attr_zero (rsp_out_attr_zero),
      .rsp_out_attr_one  (rsp_out_attr_one),
      .rsp_out_attr_two  (rsp_out_attr_two),
      .rsp_hide          (rsp_hide),
      .rsp_last          (rsp_last)
   );

`ifndef SYNTHESIS
   a_push_has_room : assert property (@(posedge clock) disable iff (reset)
      (cmd.push_sprite || cmd.push_hide || cmd.flush) |-> status.can_push)
      else $error("result pushed while the pending stage and output were both occupied");

   a_idle_nothing_pending : assert property (@(posedge clock) disable iff (reset)
      (state == ST_IDLE) |-> !status.pend_valid)
      else $error("a result was left in the pending stage after an evaluation");

   a_hide_attrs_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hide) |-> ((rsp_out_attr_zero == '0) && (rsp_out_attr_one == '0)
                                   && (rsp_out_attr_two == '0)))
      else $error("hide result carries nonzero attributes");
`endif

endmodule
`default_nettype wire

[test/sprite_band_multiplexer_core_test.sv]
// Self-checking testbench for the sprite band multiplexer core, with a scoreboard class.
`default_nettype none
module sprite_band_multiplexer_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sbm_pkg::*;

   localparam int SLOTS           = SLOT_CAPACITY_DEF;
   localparam int ENTRIES         = LIST_DEPTH_DEF;
   localparam int LINES           = SCREEN_LINES_DEF;
   localparam int IDLE_LIMIT      = 5000;
   localparam int SETTLE_CYCLES   = 300;
   localparam int RANDOM_REQUESTS = 200;

   typedef struct {
      logic [SLOT_IDX_W-1:0] slot;
      logic [ATTR_W-1:0]     attr_zero;
      logic [ATTR_W-1:0]     attr_one;
      logic [ATTR_W-1:0]     attr_two;
      logic                  hide;
      logic                  last;
   } slot_write;

   class sprite_band_scoreboard;
      logic [ATTR_W-1:0]   word_zero [ENTRIES];
      logic [ATTR_W-1:0]   word_one [ENTRIES];
      logic [ATTR_W-1:0]   word_two [ENTRIES];
      logic [BOTTOM_W-1:0] bottom [ENTRIES];
      int                  count;
      int                  prev_used;
      bit                  enabled;
      logic [BAND_W-1:0]   band_lines;
      slot_write           pending[$];
      int errors, checked, requests, evaluations, selections, hides, drops, full_bands;

      function new();
         count = 0;
         prev_used = SLOTS;
         enabled = 0;
         band_lines = 5'd4;
         errors = 0;
         checked = 0;
         requests = 0;
         evaluations = 0;
         selections = 0;
         hides = 0;
         drops = 0;
         full_bands = 0;
      endfunction

      function logic [HEIGHT_W-1:0] sprite_height(logic [1:0] shape, logic [1:0] size);
         logic [HEIGHT_W-1:0] h;
         case (shape)
            2'd0: h = 7'd8 << size;
            2'd1: h = (size == 2'd0) ? 7'd16 : (size == 2'd3) ? 7'd64 : 7'd32;
            2'd2: h = (size < 2'd2) ? 7'd8 : (size == 2'd2) ? 7'd16 : 7'd32;
            default: h = 7'd8;
         endcase
         return h;
      endfunction

      function void write_config(csr_index_type which, logic [BAND_W-1:0] data);
         if (which == CSR_ENABLE) begin
            if (data[0] && !enabled) prev_used = SLOTS;
            enabled = data[0];
         end else begin
            band_lines = data;
         end
      endfunction

      function void note_request(op_type op, logic [ATTR_W-1:0] a0, logic [ATTR_W-1:0] a1,
                                 logic [ATTR_W-1:0] a2, logic [LINE_W-1:0] start);
         int lines, last_line, used, prev, i;
         slot_write batch[$];
         slot_write w;
         requests++;
         case (op)
            OP_CLEAR: count = 0;
            OP_APPEND: begin
               if (count < ENTRIES) begin
                  word_zero[count] = a0;
                  word_one[count] = a1;
                  word_two[count] = a2;
                  bottom[count] = {1'b0, a0[7:0]} + sprite_height(a0[15:14], a1[15:14]);
                  count++;
               end else begin
                  drops++;
               end
            end
            OP_EVAL: begin
               if (enabled) begin
                  evaluations++;
                  lines = band_lines;
                  if (lines < 1) lines = 1;
                  if (lines > BAND_MAX) lines = BAND_MAX;
                  last_line = start + lines - 1;
                  if (last_line > LINES) last_line = LINES;
                  used = 0;
                  for (i = 0; i < count && used < SLOTS; i++) begin
                     if (bottom[i] >= start && word_zero[i][7:0] <= last_line) begin
                        w.slot = 6'(used);
                        w.attr_zero = word_zero[i];
                        w.attr_one = word_one[i];
                        w.attr_two = word_two[i];
                        w.hide = 1'b0;
                        w.last = 1'b0;
                        batch.push_back(w);
                        used++;
                     end
                  end
                  if (used == SLOTS) full_bands++;
                  selections += used;
                  prev = prev_used;
                  prev_used = used;
                  for (i = used; i < prev && i < SLOTS; i++) begin
                     w.slot = 6'(i);
                     w.attr_zero = '0;
                     w.attr_one = '0;
                     w.attr_two = '0;
                     w.hide = 1'b1;
                     w.last = 1'b0;
                     batch.push_back(w);
                     hides++;
                  end
                  for (i = 0; i < batch.size(); i++) begin
                     w = batch[i];
                     w.last = (i == batch.size() - 1);
                     pending.push_back(w);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) $display("MISMATCH at %0t: %s", $time, what);
      endtask

      task compare(string field, logic [ATTR_W-1:0] got, logic [ATTR_W-1:0] want);
         if (got !== want)
            report($sformatf("%s is %0h, expected %0h (result %0d)", field, got, want, checked));
      endtask

      task check_result(slot_write got);
         slot_write want;
         if (pending.size() == 0) begin
            report($sformatf("result for slot %0d with nothing expected", got.slot));
            return;
         end
         want = pending.pop_front();
         checked++;
         compare("slot", got.slot, want.slot);
         compare("attr_zero", got.attr_zero, want.attr_zero);
         compare("attr_one", got.attr_one, want.attr_one);
         compare("attr_two", got.attr_two, want.attr_two);
         compare("hide", got.hide, want.hide);
         compare("last", got.last, want.last);
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   op_type                req_operation;
   logic [ATTR_W-1:0]     req_attr_zero;
   logic [ATTR_W-1:0]     req_attr_one;
   logic [ATTR_W-1:0]     req_attr_two;
   logic [LINE_W-1:0]     req_band_start;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [SLOT_IDX_W-1:0] rsp_slot;
   logic [ATTR_W-1:0]     rsp_out_attr_zero;
   logic [ATTR_W-1:0]     rsp_out_attr_one;
   logic [ATTR_W-1:0]     rsp_out_attr_two;
   logic                  rsp_hide;
   logic                  rsp_last;
   logic                  csr_write;
   logic                  csr_index;
   logic [BAND_W-1:0]     csr_data;

   sprite_band_scoreboard board;
   slot_write             observed;
   int                    idle_cycles = 0;
   int                    burst_left = 0;
   int                    stall_mode = 0;
   int                    stall_left = 0;
   int                    random_requests = 0;
   int                    phase;
   int                    centre;
   int                    appends;
   bit                    en_plan [8] = '{1, 1, 1, 0, 1, 1, 1, 1};
   logic [BAND_W-1:0]     lines_plan [8] = '{5'd0, 5'd1, 5'd16, 5'd8, 5'd31, 5'd17, 5'd4, 5'd2};

   sprite_band_multiplexer_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_attr_zero     (req_attr_zero),
      .req_attr_one      (req_attr_one),
      .req_attr_two      (req_attr_two),
      .req_band_start    (req_band_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slot          (rsp_slot),
      .rsp_out_attr_zero (rsp_out_attr_zero),
      .rsp_out_attr_one  (rsp_out_attr_one),
      .rsp_out_attr_two  (rsp_out_attr_two),
      .rsp_hide          (rsp_hide),
      .rsp_last          (rsp_last),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 80);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            observed.slot = rsp_slot;
            observed.attr_zero = rsp_out_attr_zero;
            observed.attr_one = rsp_out_attr_one;
            observed.attr_two = rsp_out_attr_two;
            observed.hide = rsp_hide;
            observed.last = rsp_last;
            board.check_result(observed);
         end
         if (req_valid && !req_stall)
            board.note_request(req_operation, req_attr_zero, req_attr_one, req_attr_two,
                               req_band_start);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no request or result moved for %0d cycles.", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic logic [LINE_W-1:0] line_near(int middle, int below, int above);
      int v;
      v = middle - int'($urandom_range(0, below)) + int'($urandom_range(0, above));
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   task send_request(op_type op, logic [ATTR_W-1:0] a0, logic [ATTR_W-1:0] a1,
                     logic [ATTR_W-1:0] a2, logic [LINE_W-1:0] start);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_attr_zero <= a0;
      req_attr_one <= a1;
      req_attr_two <= a2;
      req_band_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      random_requests++;
   endtask

   task append_sprite(logic [LINE_W-1:0] y);
      send_request(OP_APPEND, {2'($urandom), 6'($urandom), y}, 16'($urandom), 16'($urandom),
                   8'($urandom));
   endtask

   task maybe_noise();
      if ($urandom_range(0, 14) == 0)
         send_request(OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      else if ($urandom_range(0, 29) == 0)
         send_request(OP_EVAL, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   task write_settings(bit en, logic [BAND_W-1:0] lines);
      csr_write <= 1'b1;
      csr_index <= CSR_ENABLE;
      csr_data <= {4'd0, en};
      board.write_config(CSR_ENABLE, {4'd0, en});
      @(posedge clock);
      csr_index <= CSR_BAND_HEIGHT;
      csr_data <= lines;
      board.write_config(CSR_BAND_HEIGHT, lines);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task wait_idle();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      board = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_CLEAR;
      req_attr_zero <= '0;
      req_attr_one <= '0;
      req_attr_two <= '0;
      req_band_start <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_ENABLE;
      csr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_settings(1'b1, 5'd16);

      // Empty list right after enabling hides every slot, then a second pass writes nothing.
      send_request(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 8'd0);
      send_request(OP_EVAL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0);
      send_request(OP_APPEND, 16'h0000, 16'h0000, 16'h0000, 8'd0);
      send_request(OP_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_request(OP_APPEND, {2'b01, 6'h15, 8'd10}, {2'b01, 14'h1234}, 16'h5A5A, 8'd0);
      send_request(OP_APPEND, {2'b10, 6'h2A, 8'd200}, {2'b11, 14'h0F0F}, 16'hA5A5, 8'd0);
      send_request(OP_APPEND, {2'b00, 6'h3F, 8'd250}, {2'b11, 14'h3FFF}, 16'h1234, 8'd0);
      send_request(OP_APPEND, {2'b01, 6'h00, 8'd180}, {2'b00, 14'h2222}, 16'h8001, 8'd0);
      send_request(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_request(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 8'd0);
      send_request(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 8'd255);
      send_request(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 8'd192);
      send_request(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 8'd190);
      send_request(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 8'd8);
      send_request(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 8'd20);
      send_request(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 8'd0);
      send_request(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 8'd0);
      send_request(OP_APPEND, {2'b10, 6'h11, 8'd100}, {2'b00, 14'h0ABC}, 16'h7777, 8'd0);
      send_request(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 8'd96);
      send_request(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 8'd108);
      send_request(OP_EVAL, 16'h0000, 16'h0000, 16'h0000, 8'd109);

      random_requests = 0;
      phase = 0;
      while (random_requests < RANDOM_REQUESTS) begin
         wait_idle();
         if (phase < 8) write_settings(en_plan[phase], lines_plan[phase]);
         else write_settings($urandom_range(0, 3) != 0, 5'($urandom_range(0, 31)));
         centre = $urandom_range(0, 200);
         if ($urandom_range(0, 3) != 0)
            send_request(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
         appends = (phase == 2) ? ENTRIES + 2 : $urandom_range(0, 24);
         repeat (appends) begin
            maybe_noise();
            append_sprite(($urandom_range(0, 3) == 0) ? 8'($urandom) : line_near(centre, 40, 12));
         end
         repeat ($urandom_range(2, 8)) begin
            maybe_noise();
            send_request(OP_EVAL, 16'($urandom), 16'($urandom), 16'($urandom),
                         ($urandom_range(0, 4) == 0) ? 8'($urandom) : line_near(centre, 20, 20));
         end
         phase++;
      end

      wait_idle();
      $display("Run covered %0d requests in %0d phases: %0d band evaluations, %0d placements, %0d hides.",
               board.requests, phase, board.evaluations, board.selections, board.hides);
      $display("Appends dropped on a full list: %0d; bands at slot capacity: %0d; mismatches: %0d.",
               board.drops, board.full_bands, board.errors);
      if (board.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire
